/* rtl/segment_line_intersection_unit_assert.svh */
// Assertion macros for the segment / line intersection unit.
// Used by segment_line_intersection_unit.sv; no other dependencies.
`ifndef SEGMENT_LINE_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_LINE_INTERSECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define SLI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sli_pkg.sv */
// Shared widths, register codes, stage numbers and types of the intersection unit.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package sli_pkg;

   localparam int COORD_BITS  = 16;
   localparam int T_FRAC_BITS = 16;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int DEN_W  = PROD_W + 1;
   localparam int REM_W  = DEN_W + 1;
   localparam int Q_W    = T_FRAC_BITS + 1;
   localparam int T_W    = T_FRAC_BITS + 3;
   localparam int MUL_W  = DIFF_W + T_W;

   localparam int EPS_W      = 16;
   localparam int TB_W       = T_FRAC_BITS + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = (TB_W > EPS_W) ? TB_W : EPS_W;

   localparam logic [CSR_IDX_W-1:0] CSR_DENOM_EPSILON = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_T_LOW         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_T_HIGH        = 2'd2;

   localparam logic [EPS_W-1:0] RST_DENOM_EPSILON = EPS_W'(1);
   localparam logic [TB_W-1:0]  RST_T_LOW         = TB_W'(7);
   localparam logic [TB_W-1:0]  RST_T_HIGH        = TB_W'((1 << T_FRAC_BITS) - 7);

   localparam logic [T_W-1:0] T_SAT = T_W'(1 << (T_FRAC_BITS + 1));

   // pipeline stage numbers
   localparam int S_DIFF   = 0;
   localparam int S_PROD   = 1;
   localparam int S_SUM    = 2;
   localparam int S_MAG    = 3;
   localparam int S_INIT   = 4;
   localparam int S_TSGN   = S_INIT + T_FRAC_BITS + 1;
   localparam int S_MUL    = S_TSGN + 1;
   localparam int N_STAGES = S_MUL + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic signed [DIFF_W-1:0]     dx12;
      logic signed [DIFF_W-1:0]     dy12;
      logic                         neg;
      logic                         miss;
      logic                         sat;
   } div_pay_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] cross_x;
      logic signed [COORD_BITS-1:0] cross_y;
   } res_type;

endpackage

/* rtl/sli_req_if.sv */
// Input channel of the intersection unit: two segment end points and two line points.
// Depends on sli_pkg.
`timescale 1ns / 1ps

interface sli_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sli_pkg::COORD_BITS-1:0] ax0;
   logic signed [sli_pkg::COORD_BITS-1:0] ay0;
   logic signed [sli_pkg::COORD_BITS-1:0] ax1;
   logic signed [sli_pkg::COORD_BITS-1:0] ay1;
   logic signed [sli_pkg::COORD_BITS-1:0] bx0;
   logic signed [sli_pkg::COORD_BITS-1:0] by0;
   logic signed [sli_pkg::COORD_BITS-1:0] bx1;
   logic signed [sli_pkg::COORD_BITS-1:0] by1;

   modport source (output valid, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, input ready);
   modport sink   (input valid, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, output ready);
endinterface

/* rtl/sli_rsp_if.sv */
// Result channel of the intersection unit: hit flag and intersection point.
// Depends on sli_pkg.
`timescale 1ns / 1ps

interface sli_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   hit;
   logic signed [sli_pkg::COORD_BITS-1:0] cross_x;
   logic signed [sli_pkg::COORD_BITS-1:0] cross_y;

   modport source (output valid, hit, cross_x, cross_y, input ready);
   modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

/* rtl/sli_csr_if.sv */
// Register write channel of the intersection unit: register index and write data.
// Depends on sli_pkg.
`timescale 1ns / 1ps

interface sli_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sli_pkg::CSR_IDX_W-1:0]       index;
   logic [sli_pkg::CSR_DATA_W-1:0]      wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

/* rtl/segment_line_intersection_unit.sv */
// Channel    | dir | handshake       | payload
// req_chan   | in  | valid / ready   | ax0 ay0 ax1 ay1 bx0 by0 bx1 by1
// rsp_chan   | out | valid / ready   | hit cross_x cross_y
// csr_chan   | in  | valid / ready=1 | index wdata
//
// One item per cycle while req_chan.ready is high; t is a signed Q2.16 value formed by the
// one-bit-per-stage restoring divider.
// The pipeline moves as a whole; a two-entry output queue (head + skid) lets it keep
// taking items while one result waits. req_chan.ready drops only when both are full.
// Synchronous reset clears valid bits and loads the register defaults.
// Depends on sli_pkg, the sli_*_if interfaces and segment_line_intersection_unit_assert.svh.
`timescale 1ns / 1ps

`include "segment_line_intersection_unit_assert.svh"

module segment_line_intersection_unit (
   input  logic      clock,
   input  logic      reset,
   sli_req_if.sink   req_chan,
   sli_rsp_if.source rsp_chan,
   sli_csr_if.sink   csr_chan
);

   localparam int CB = sli_pkg::COORD_BITS;
   localparam int DW = sli_pkg::DIFF_W;
   localparam int PW = sli_pkg::PROD_W;
   localparam int NW = sli_pkg::DEN_W;
   localparam int RW = sli_pkg::REM_W;
   localparam int QW = sli_pkg::Q_W;
   localparam int TW = sli_pkg::T_W;
   localparam int MW = sli_pkg::MUL_W;
   localparam int FB = sli_pkg::T_FRAC_BITS;

   // registers
   logic [sli_pkg::EPS_W-1:0] eps_ff;
   logic [sli_pkg::TB_W-1:0]  t_low_ff;
   logic [sli_pkg::TB_W-1:0]  t_high_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff    <= sli_pkg::RST_DENOM_EPSILON;
         t_low_ff  <= sli_pkg::RST_T_LOW;
         t_high_ff <= sli_pkg::RST_T_HIGH;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            sli_pkg::CSR_DENOM_EPSILON: eps_ff <= csr_chan.wdata[sli_pkg::EPS_W-1:0];
            sli_pkg::CSR_T_LOW:         t_low_ff <= csr_chan.wdata[sli_pkg::TB_W-1:0];
            sli_pkg::CSR_T_HIGH:        t_high_ff <= csr_chan.wdata[sli_pkg::TB_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic                          en;
   logic [sli_pkg::N_STAGES-1:0] stg_v_ff;
   logic                          head_v_ff;
   logic                          skid_v_ff;

   assign en             = !skid_v_ff;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff <= '0;
      end else if (en) begin
         stg_v_ff <= {stg_v_ff[sli_pkg::N_STAGES-2:0], req_chan.valid};
      end
   end

   // differences
   logic signed [DW-1:0] s1_dx12_ff, s1_dy12_ff, s1_dx34_ff, s1_dy34_ff;
   logic signed [DW-1:0] s1_dx13_ff, s1_dy31_ff;
   logic signed [CB-1:0] s1_x1_ff, s1_y1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx12_ff <= DW'(req_chan.ax1) - DW'(req_chan.ax0);
         s1_dy12_ff <= DW'(req_chan.ay1) - DW'(req_chan.ay0);
         s1_dx34_ff <= DW'(req_chan.bx1) - DW'(req_chan.bx0);
         s1_dy34_ff <= DW'(req_chan.by1) - DW'(req_chan.by0);
         s1_dx13_ff <= DW'(req_chan.ax0) - DW'(req_chan.bx0);
         s1_dy31_ff <= DW'(req_chan.by0) - DW'(req_chan.ay0);
         s1_x1_ff   <= req_chan.ax0;
         s1_y1_ff   <= req_chan.ay0;
      end
   end

   // cross products
   logic signed [PW-1:0] s2_pa_ff, s2_pb_ff, s2_pc_ff, s2_pd_ff;
   logic signed [DW-1:0] s2_dx12_ff, s2_dy12_ff;
   logic signed [CB-1:0] s2_x1_ff, s2_y1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pa_ff   <= s1_dy12_ff * s1_dx34_ff;
         s2_pb_ff   <= s1_dy34_ff * s1_dx12_ff;
         s2_pc_ff   <= s1_dy34_ff * s1_dx13_ff;
         s2_pd_ff   <= s1_dx34_ff * s1_dy31_ff;
         s2_dx12_ff <= s1_dx12_ff;
         s2_dy12_ff <= s1_dy12_ff;
         s2_x1_ff   <= s1_x1_ff;
         s2_y1_ff   <= s1_y1_ff;
      end
   end

   // denominator and numerator
   logic signed [NW-1:0] s3_den_ff, s3_num_ff;
   logic signed [DW-1:0] s3_dx12_ff, s3_dy12_ff;
   logic signed [CB-1:0] s3_x1_ff, s3_y1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_den_ff  <= NW'(s2_pa_ff) - NW'(s2_pb_ff);
         s3_num_ff  <= NW'(s2_pc_ff) + NW'(s2_pd_ff);
         s3_dx12_ff <= s2_dx12_ff;
         s3_dy12_ff <= s2_dy12_ff;
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
      end
   end

   // magnitudes and quotient sign
   logic [NW-1:0]        s4_b_ff, s4_a_ff;
   logic                 s4_neg_ff;
   logic signed [DW-1:0] s4_dx12_ff, s4_dy12_ff;
   logic signed [CB-1:0] s4_x1_ff, s4_y1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_b_ff    <= s3_den_ff[NW-1] ? unsigned'(-s3_den_ff) : unsigned'(s3_den_ff);
         s4_a_ff    <= s3_num_ff[NW-1] ? unsigned'(-s3_num_ff) : unsigned'(s3_num_ff);
         s4_neg_ff  <= s3_num_ff[NW-1] ^ s3_den_ff[NW-1];
         s4_dx12_ff <= s3_dx12_ff;
         s4_dy12_ff <= s3_dy12_ff;
         s4_x1_ff   <= s3_x1_ff;
         s4_y1_ff   <= s3_y1_ff;
      end
   end

   // divider: entry 0 is the integer bit, each following entry one fraction bit
   logic [RW-1:0]        div_rem_ff [FB+1];
   logic [QW-1:0]        div_quo_ff [FB+1];
   logic [NW-1:0]        div_b_ff   [FB+1];
   sli_pkg::div_pay_type div_pay_ff [FB+1];

   logic      init_ge;
   logic      init_sat;
   logic [RW-1:0] init_a;

   assign init_a   = RW'(s4_a_ff);
   assign init_ge  = s4_a_ff >= s4_b_ff;
   assign init_sat = init_a >= {s4_b_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         div_rem_ff[0]      <= init_ge ? init_a - RW'(s4_b_ff) : init_a;
         div_quo_ff[0]      <= QW'(init_ge);
         div_b_ff[0]        <= s4_b_ff;
         div_pay_ff[0].x1   <= s4_x1_ff;
         div_pay_ff[0].y1   <= s4_y1_ff;
         div_pay_ff[0].dx12 <= s4_dx12_ff;
         div_pay_ff[0].dy12 <= s4_dy12_ff;
         div_pay_ff[0].neg  <= s4_neg_ff;
         div_pay_ff[0].miss <= (s4_b_ff == '0) || (s4_b_ff < NW'(eps_ff));
         div_pay_ff[0].sat  <= init_sat;
      end
   end

   for (genvar j = 0; j < FB; j++) begin : g_div
      logic [RW-1:0] step_r2;
      logic          step_ge;

      assign step_r2 = {div_rem_ff[j][RW-2:0], 1'b0};
      assign step_ge = step_r2 >= RW'(div_b_ff[j]);

      always_ff @(posedge clock) begin
         if (en) begin
            div_rem_ff[j+1] <= step_ge ? step_r2 - RW'(div_b_ff[j]) : step_r2;
            div_quo_ff[j+1] <= {div_quo_ff[j][QW-2:0], step_ge};
            div_b_ff[j+1]   <= div_b_ff[j];
            div_pay_ff[j+1] <= div_pay_ff[j];
         end
      end
   end

   // signed t
   logic [TW-1:0]        t_mag;
   logic signed [TW-1:0] st_t_ff;
   logic signed [DW-1:0] st_dx12_ff, st_dy12_ff;
   logic signed [CB-1:0] st_x1_ff, st_y1_ff;
   logic                 st_miss_ff;

   assign t_mag = div_pay_ff[FB].sat ? sli_pkg::T_SAT : TW'(div_quo_ff[FB]);

   always_ff @(posedge clock) begin
      if (en) begin
         st_t_ff    <= div_pay_ff[FB].neg ? -signed'(t_mag) : signed'(t_mag);
         st_dx12_ff <= div_pay_ff[FB].dx12;
         st_dy12_ff <= div_pay_ff[FB].dy12;
         st_x1_ff   <= div_pay_ff[FB].x1;
         st_y1_ff   <= div_pay_ff[FB].y1;
         st_miss_ff <= div_pay_ff[FB].miss;
      end
   end

   // range check and scaling
   logic signed [MW-1:0] sm_px_ff, sm_py_ff;
   logic signed [CB-1:0] sm_x1_ff, sm_y1_ff;
   logic                 sm_miss_ff;
   logic                 t_in_range;

   assign t_in_range = (st_t_ff >= signed'(TW'(t_low_ff))) &&
                       (st_t_ff <= signed'(TW'(t_high_ff)));

   always_ff @(posedge clock) begin
      if (en) begin
         sm_px_ff   <= st_dx12_ff * st_t_ff;
         sm_py_ff   <= st_dy12_ff * st_t_ff;
         sm_x1_ff   <= st_x1_ff;
         sm_y1_ff   <= st_y1_ff;
         sm_miss_ff <= st_miss_ff || !t_in_range;
      end
   end

   // final point
   sli_pkg::res_type res_new;

   always_comb begin
      res_new.hit     = !sm_miss_ff;
      res_new.cross_x = '0;
      res_new.cross_y = '0;
      if (!sm_miss_ff) begin
         res_new.cross_x = sm_x1_ff + sm_px_ff[FB+CB-1:FB];
         res_new.cross_y = sm_y1_ff + sm_py_ff[FB+CB-1:FB];
      end
   end

   // output queue: head register plus skid register
   sli_pkg::res_type head_ff, skid_ff;
   logic             push, pop;

   assign push = en && stg_v_ff[sli_pkg::S_MUL];
   assign pop  = head_v_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (head_v_ff && !pop) begin
            skid_v_ff <= 1'b1;
         end
         head_v_ff <= 1'b1;
      end else if (pop) begin
         head_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            head_ff <= skid_ff;
         end
      end else if (push) begin
         if (head_v_ff && !pop) begin
            skid_ff <= res_new;
         end else begin
            head_ff <= res_new;
         end
      end
   end

   assign rsp_chan.valid   = head_v_ff;
   assign rsp_chan.hit     = head_ff.hit;
   assign rsp_chan.cross_x = head_ff.cross_x;
   assign rsp_chan.cross_y = head_ff.cross_y;

   `SLI_ASSERT_NOW(a_miss_zero, clock, reset, rsp_chan.valid && !rsp_chan.hit, (rsp_chan.cross_x == '0) && (rsp_chan.cross_y == '0), "miss item carries a nonzero point")
   `SLI_ASSERT_NOW(a_skid_behind_head, clock, reset, skid_v_ff, head_v_ff, "skid holds an item while head is empty")
   `SLI_ASSERT_NOW(a_rem_below_div, clock, reset, stg_v_ff[sli_pkg::S_TSGN - 1] && !div_pay_ff[FB].sat && (div_b_ff[FB] != '0), div_rem_ff[FB] < RW'(div_b_ff[FB]), "divider remainder not below divisor")
   `SLI_ASSERT_NEXT(a_accept_enters, clock, reset, req_chan.valid && req_chan.ready, stg_v_ff[sli_pkg::S_DIFF], "accepted item missing from first stage")

endmodule
